### hw/rtl/rbhe_pkg.sv
// package for the rms bin hit extractor: sizes, field codes and stage structs
// no dependencies; imported by the top level, rbhe_in_stage and rbhe_detect
`default_nettype none

package rbhe_pkg;

   // block configuration
   localparam int BIN_SIZE       = 100;
   localparam int EXTRACT_LENGTH = 4096;
   localparam int STORE_DEPTH    = 131072;

   // fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int IDX_W    = 12;
   localparam int THR_W    = 15;
   localparam int HIT_W    = 17;

   // derived widths
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int FILL_W   = $clog2(BIN_SIZE);
   localparam int SQ_W     = 2 * SAMPLE_W - 1;
   localparam int THR_SQ_W = 2 * THR_W;
   localparam longint unsigned MAX_SUM = longint'(BIN_SIZE) << (2 * SAMPLE_W - 2);
   localparam int SUM_W    = $clog2(MAX_SUM + 64'd1);

   // command and result kind codes
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_READ     = 1'b1;
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   // input register contents
   typedef struct packed {
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      logic [IDX_W-1:0]           idx;
      logic [SQ_W-1:0]            sq;
   } p1_type;

   // post-update stage contents, aligned with the store read data
   typedef struct packed {
      logic             kind;
      logic [HIT_W-1:0] hit_start;
      logic             found;
      logic             rd_ok;
   } p2_type;

endpackage

`default_nettype wire

### hw/rtl/rbhe_req_if.sv
// request channel interface: valid/ready handshake with the input item fields
// depends on nothing; used by rbhe_in_stage and the top level
`default_nettype none

interface rbhe_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [15:0] sample_in;
   logic               last_sample;
   logic [11:0]        read_index;

   modport source (output valid, cmd, sample_in, last_sample, read_index, input ready);
   modport sink   (input valid, cmd, sample_in, last_sample, read_index, output ready);
endinterface

`default_nettype wire

### hw/rtl/rbhe_rsp_if.sv
// response channel interface: valid/ready handshake with the result item fields
// depends on nothing; used by the top level
`default_nettype none

interface rbhe_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [16:0]        hit_start;
   logic               hit_found;
   logic signed [15:0] sample_out;

   modport source (output valid, result_kind, hit_start, hit_found, sample_out, input ready);
   modport sink   (input valid, result_kind, hit_start, hit_found, sample_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/rms_bin_hit_extractor.sv
// top level of the rms bin hit extractor: input stage, detection core, result register
// depends on rbhe_pkg, rbhe_req_if, rbhe_rsp_if, rbhe_in_stage, rbhe_detect
//
//  channel    direction  handshake             payload
//  req_chan   in         valid / ready         cmd, sample_in, last_sample, read_index
//  rsp_chan   out        valid / ready         result_kind, hit_start, hit_found, sample_out
//  csr        in         csr_write_en          csr_write_data (rms threshold)
//
// one transaction per cycle while rsp_chan does not stall; a result passes the input register,
// the store-read stage (registered read of the sample store) and the result register
// reset clears all control state; the sample store is not cleared and its read data is
// only used below the loaded length, so no clearing pass runs after reset
// a stall on rsp_chan fills the result register, then the store-read stage, then the
// input register before req_chan.ready drops
`default_nettype none

module rms_bin_hit_extractor
   import rbhe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_en,
   input  wire logic [THR_W-1:0]  csr_write_data,
   rbhe_req_if.sink               req_chan,
   rbhe_rsp_if.source             rsp_chan
);

   // input register to detection core
   logic   p1_valid;
   p1_type p1;
   logic   take;

   // detection core to result register
   logic                p2_valid;
   p2_type              p2;
   logic [SAMPLE_W-1:0] rd_data;

   // result register
   logic                       out_valid_ff, out_valid_in;
   logic                       out_kind_ff,  out_kind_in;
   logic [HIT_W-1:0]           out_hit_ff,   out_hit_in;
   logic                       out_found_ff, out_found_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_take;

   // result register can load when empty or being drained this cycle
   assign out_take = !out_valid_ff || rsp_chan.ready;

   rbhe_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .p1_valid (p1_valid),
      .p1       (p1)
   );

   rbhe_detect u_detect (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .p1_valid       (p1_valid),
      .p1             (p1),
      .out_take       (out_take),
      .take           (take),
      .p2_valid       (p2_valid),
      .p2             (p2),
      .rd_data        (rd_data)
   );

   // store data only for reads inside the loaded length, zero otherwise
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_hit_in    = out_hit_ff;
      out_found_in  = out_found_ff;
      out_sample_in = out_sample_ff;
      if (out_take) begin
         out_valid_in  = p2_valid;
         out_kind_in   = p2.kind;
         out_hit_in    = p2.hit_start;
         out_found_in  = p2.found;
         out_sample_in = (p2.kind == KIND_READ && p2.rd_ok) ? $signed(rd_data) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_hit_ff    <= out_hit_in;
      out_found_ff  <= out_found_in;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = out_kind_ff;
   assign rsp_chan.hit_start   = out_hit_ff;
   assign rsp_chan.hit_found   = out_found_ff;
   assign rsp_chan.sample_out  = out_sample_ff;

endmodule

`default_nettype wire

### hw/rtl/rbhe_ram.sv
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module rbhe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/rbhe_in_stage.sv
// input register stage: takes request transactions and squares the sample
// depends on rbhe_pkg and rbhe_req_if
`default_nettype none

module rbhe_in_stage
   import rbhe_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rbhe_req_if.sink    req_chan,
   input  wire logic   take,
   output      logic   p1_valid,
   output      p1_type p1
);

   logic   valid_ff;
   logic   valid_in;
   p1_type data_ff;
   p1_type data_in;
   logic   accept;
   logic signed [2*SAMPLE_W-1:0] product;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      product      = req_chan.sample_in * req_chan.sample_in;
      data_in.cmd    = req_chan.cmd;
      data_in.sample = req_chan.sample_in;
      data_in.last   = req_chan.last_sample;
      data_in.idx    = req_chan.read_index;
      data_in.sq     = product[SQ_W-1:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign p1_valid = valid_ff;
   assign p1       = data_ff;

endmodule

`default_nettype wire

### hw/rtl/rbhe_detect.sv
// detection core: bin accumulation, best bin tracking, sample store and read issue
// depends on rbhe_pkg and rbhe_ram
`default_nettype none

module rbhe_detect
   import rbhe_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_en,
   input  wire logic [THR_W-1:0]    csr_write_data,
   input  wire logic                p1_valid,
   input  wire p1_type              p1,
   input  wire logic                out_take,
   output      logic                take,
   output      logic                p2_valid,
   output      p2_type              p2,
   output      logic [SAMPLE_W-1:0] rd_data
);

   // threshold, kept as squared limit over one bin
   logic [THR_SQ_W-1:0] thr_sq_ff;
   logic [SUM_W-1:0]    limit_ff;

   // recording state
   logic [CNT_W-1:0]  load_count_ff,  load_count_in;
   logic [FILL_W-1:0] bin_fill_ff,    bin_fill_in;
   logic [SUM_W-1:0]  bin_sum_ff,     bin_sum_in;
   logic [SUM_W-1:0]  best_sum_ff,    best_sum_in;
   logic [ADDR_W-1:0] best_start_ff,  best_start_in;
   logic              found_ff,       found_in;
   logic [CNT_W-1:0]  loaded_len_ff,  loaded_len_in;

   logic   p2_valid_ff, p2_valid_in;
   p2_type p2_ff,       p2_in;

   logic              process;
   logic              fresh;
   logic              has_room;
   logic              close;
   logic              qualify;
   logic [SUM_W-1:0]  bin_sum_base;
   logic [SUM_W-1:0]  best_sum_base;
   logic [ADDR_W-1:0] best_start_base;
   logic              found_base;
   logic [FILL_W-1:0] fill_base;
   logic [SUM_W-1:0]  sum_acc;
   logic [ADDR_W-1:0] bin_start;
   logic [CNT_W-1:0]  rd_sum;
   logic              rd_ok;
   logic              wr_en;
   logic              rd_en;

   assign take    = !p2_valid_ff || out_take;
   assign process = p1_valid && take;

   always_comb begin
      fresh           = (load_count_ff == '0);
      has_room        = (load_count_ff < CNT_W'(STORE_DEPTH));
      bin_sum_base    = fresh ? '0 : bin_sum_ff;
      best_sum_base   = fresh ? '0 : best_sum_ff;
      best_start_base = fresh ? '0 : best_start_ff;
      found_base      = fresh ? 1'b0 : found_ff;
      fill_base       = fresh ? '0 : bin_fill_ff;
      sum_acc         = bin_sum_base + SUM_W'(p1.sq);
      close           = (fill_base == FILL_W'(BIN_SIZE - 1));
      qualify         = (sum_acc > limit_ff) && (!found_base || (sum_acc > best_sum_base));
      bin_start       = ADDR_W'(load_count_ff - CNT_W'(BIN_SIZE - 1));
      rd_sum          = CNT_W'(best_start_ff) + CNT_W'(p1.idx);
      rd_ok           = (32'(p1.idx) < EXTRACT_LENGTH) && (rd_sum < loaded_len_ff)
                        && (rd_sum < CNT_W'(STORE_DEPTH));
   end

   // state update for one processed transaction
   always_comb begin
      load_count_in = load_count_ff;
      bin_fill_in   = bin_fill_ff;
      bin_sum_in    = bin_sum_ff;
      best_sum_in   = best_sum_ff;
      best_start_in = best_start_ff;
      found_in      = found_ff;
      loaded_len_in = loaded_len_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      if (process) begin
         if (p1.cmd == CMD_LOAD) begin
            bin_sum_in    = bin_sum_base;
            best_sum_in   = best_sum_base;
            best_start_in = best_start_base;
            found_in      = found_base;
            bin_fill_in   = fill_base;
            if (has_room) begin
               wr_en         = 1'b1;
               load_count_in = load_count_ff + 1'b1;
               bin_sum_in    = sum_acc;
               bin_fill_in   = fill_base + 1'b1;
               if (close) begin
                  bin_sum_in  = '0;
                  bin_fill_in = '0;
                  if (qualify) begin
                     best_sum_in   = sum_acc;
                     best_start_in = bin_start;
                     found_in      = 1'b1;
                  end
               end
            end
            if (p1.last) begin
               // trailing partial bin is dropped here
               loaded_len_in = load_count_in;
               load_count_in = '0;
               bin_sum_in    = '0;
               bin_fill_in   = '0;
            end
         end else begin
            rd_en = 1'b1;
         end
      end
   end

   // next contents of the stage that waits for the store read
   always_comb begin
      p2_valid_in = p2_valid_ff;
      p2_in       = p2_ff;
      if (take) begin
         p2_valid_in = process && ((p1.cmd == CMD_READ) || p1.last);
         if (p1.cmd == CMD_LOAD) begin
            p2_in.kind      = KIND_SUMMARY;
            p2_in.hit_start = found_in ? HIT_W'(best_start_in) : '0;
            p2_in.found     = found_in;
            p2_in.rd_ok     = 1'b0;
         end else begin
            p2_in.kind      = KIND_READ;
            p2_in.hit_start = HIT_W'(best_start_ff);
            p2_in.found     = found_ff;
            p2_in.rd_ok     = rd_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_sq_ff     <= '0;
         limit_ff      <= '0;
         load_count_ff <= '0;
         bin_fill_ff   <= '0;
         bin_sum_ff    <= '0;
         best_sum_ff   <= '0;
         best_start_ff <= '0;
         found_ff      <= 1'b0;
         loaded_len_ff <= '0;
         p2_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            thr_sq_ff <= THR_SQ_W'(csr_write_data * csr_write_data);
         end
         limit_ff      <= SUM_W'(thr_sq_ff * SUM_W'(BIN_SIZE));
         load_count_ff <= load_count_in;
         bin_fill_ff   <= bin_fill_in;
         bin_sum_ff    <= bin_sum_in;
         best_sum_ff   <= best_sum_in;
         best_start_ff <= best_start_in;
         found_ff      <= found_in;
         loaded_len_ff <= loaded_len_in;
         p2_valid_ff   <= p2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p2_ff <= p2_in;
   end

   rbhe_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_count_ff[ADDR_W-1:0]),
      .wr_data (p1.sample),
      .rd_en   (rd_en),
      .rd_addr (rd_sum[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign p2_valid = p2_valid_ff;
   assign p2       = p2_ff;

endmodule

`default_nettype wire
